FILE: design/blid_pkg.sv
// Shared types and constants for the bounded list block.
package blid_pkg;

  localparam int DataW = 32;
  localparam int OpW   = 2;
  localparam int PosW  = 6;

  typedef enum logic [OpW-1:0] {
    OpFront  = 2'd0,
    OpBack   = 2'd1,
    OpDelete = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StDump
  } state_e;

endpackage

FILE: design/blid_ram.sv
// Entry store: one write port and one read port with registered read data.
module blid_ram #(
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [blid_pkg::DataW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [blid_pkg::DataW-1:0] rdata_o
);
  import blid_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/blid_idx.sv
// Shared index unit: adds a logical offset to the ring head and wraps at the capacity.
module blid_idx #(
  parameter int Capacity = 16,
  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic [IdxW-1:0] base_i,
  input  logic [IdxW-1:0] off_i,
  output logic [IdxW-1:0] idx_o
);

  logic [IdxW:0] sum;
  logic [IdxW:0] wrapped;

  always_comb begin
    sum     = {1'b0, base_i} + {1'b0, off_i};
    wrapped = sum - (IdxW+1)'(Capacity);
    if (sum >= (IdxW+1)'(Capacity)) begin
      idx_o = wrapped[IdxW-1:0];
    end else begin
      idx_o = sum[IdxW-1:0];
    end
  end

endmodule

FILE: design/bounded_list_insert_delete_dump_top.sv
// Top level of the bounded list: sequencer, ring head, count and result registers.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit words in a
// ring held in a single-port-write, single-port-read memory. A command is taken
// when start is high and busy is low. A front insert or a back append writes
// one word in the accept cycle unless the list is full. A delete moves every
// word behind the deleted position one place toward the front, one word per
// cycle through the memory read port. Then the whole list is dumped, front
// first, one word per cycle: a list of n words gives n results, an empty list
// a single result with empty_res_o set and item_o zero. Busy stays high
// through the move and the dump, and the moves and the dump share the memory
// read port. Each result word is shown for exactly one cycle with out_strobe_o
// high, and the receiver cannot stall it. The last word of a dump appears in
// the cycle in which busy is already low again, so it can overlap the
// acceptance of the next command.
module bounded_list_insert_delete_dump_top #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [blid_pkg::OpW-1:0]          op_i,
  input  logic signed [blid_pkg::DataW-1:0] value_i,
  input  logic [blid_pkg::PosW-1:0]         position_i,
  output logic                              out_strobe_o,
  output logic signed [blid_pkg::DataW-1:0] item_o,
  output logic                              last_o,
  output logic                              empty_res_o,
  output logic                              refused_o
);
  import blid_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + PosW;

  state_e         state_q, state_d;
  logic [IW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  // Logical index of the next word to read during a move or a dump.
  logic [CW-1:0]  j_q, j_d;
  // Physical slot that receives the word read next during a move.
  logic [IW-1:0]  cur_q, cur_d;
  logic [IW-1:0]  wdst_q, wdst_d;
  logic           pend_q, pend_d;
  logic           ref_q, ref_d;

  logic           out_strobe_q, out_strobe_d;
  logic           out_last_q, out_last_d;
  logic           out_empty_q, out_empty_d;
  logic           out_ref_q, out_ref_d;

  logic [IW-1:0]    idx_off;
  logic [IW-1:0]    idx_res;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [DataW-1:0] mem_rdata;
  logic             full;
  logic             pos_ok;

  blid_idx #(
    .Capacity(CAPACITY)
  ) u_idx (
    .base_i(head_q),
    .off_i (idx_off),
    .idx_o (idx_res)
  );

  blid_ram #(
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx_res),
    .rdata_o(mem_rdata)
  );

  assign full   = (count_q == CW'(CAPACITY));
  assign pos_ok = (XW'(position_i) < XW'(count_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      count_q      <= '0;
      j_q          <= '0;
      pend_q       <= 1'b0;
      ref_q        <= 1'b0;
      out_strobe_q <= 1'b0;
      out_last_q   <= 1'b0;
      out_empty_q  <= 1'b0;
      out_ref_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      j_q          <= j_d;
      pend_q       <= pend_d;
      ref_q        <= ref_d;
      out_strobe_q <= out_strobe_d;
      out_last_q   <= out_last_d;
      out_empty_q  <= out_empty_d;
      out_ref_q    <= out_ref_d;
    end
  end

  // Slot pointers only matter while a move is in flight.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    wdst_q <= wdst_d;
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    j_d          = j_q;
    cur_d        = cur_q;
    wdst_d       = wdst_q;
    pend_d       = 1'b0;
    ref_d        = ref_q;
    out_strobe_d = 1'b0;
    out_last_d   = 1'b0;
    out_empty_d  = 1'b0;
    out_ref_d    = ref_q;
    idx_off      = '0;
    mem_we       = 1'b0;
    mem_waddr    = wdst_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          ref_d   = 1'b0;
          j_d     = '0;
          state_d = StDump;
          case (op_e'(op_i))
            OpFront: begin
              // The slot before the head becomes the new front.
              idx_off = IW'(CAPACITY - 1);
              if (full) begin
                ref_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_res;
                mem_wdata = value_i;
                head_d    = idx_res;
                count_d   = count_q + CW'(1);
              end
            end
            OpBack: begin
              idx_off = count_q[IW-1:0];
              if (full) begin
                ref_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_res;
                mem_wdata = value_i;
                count_d   = count_q + CW'(1);
              end
            end
            OpDelete: begin
              idx_off = position_i[IW-1:0];
              if (pos_ok) begin
                cur_d   = idx_res;
                j_d     = CW'(position_i) + CW'(1);
                state_d = StShift;
              end
            end
            default: begin
              state_d = StDump;
            end
          endcase
        end
      end

      StShift: begin
        // A word read in the previous cycle lands one slot toward the front.
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (j_q < count_q) begin
          idx_off = j_q[IW-1:0];
          mem_re  = 1'b1;
          pend_d  = 1'b1;
          wdst_d  = cur_q;
          cur_d   = idx_res;
          j_d     = j_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          j_d     = '0;
          state_d = StDump;
        end
      end

      StDump: begin
        out_strobe_d = 1'b1;
        if (count_q == '0) begin
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          state_d     = StIdle;
        end else begin
          idx_off    = j_q[IW-1:0];
          mem_re     = 1'b1;
          j_d        = j_q + CW'(1);
          out_last_d = ((j_q + CW'(1)) == count_q);
          if (out_last_d) begin
            state_d = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy         = (state_q != StIdle);
  assign out_strobe_o = out_strobe_q;
  assign item_o       = out_empty_q ? '0 : mem_rdata;
  assign last_o       = out_last_q;
  assign empty_res_o  = out_empty_q;
  assign refused_o    = out_ref_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_empty_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && empty_res_o) |-> last_o)
    else $error("empty result not marked last");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_refused_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && refused_o) |-> full)
    else $error("refused result while list not full");

  a_move_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == StShift))
    else $error("pending move word outside the move phase");
`endif

endmodule

FILE: tb/sv/blid_list_checker.sv
// Checker for the bounded list: predicts every dump from accepted commands and compares each word.
module blid_list_checker
  import blid_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic [OpW-1:0]           op_i,
  input  logic signed [DataW-1:0]  value_i,
  input  logic [PosW-1:0]          position_i,
  input  logic                     out_strobe_o,
  input  logic signed [DataW-1:0]  item_o,
  input  logic                     last_o,
  input  logic                     empty_res_o,
  input  logic                     refused_o,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic signed [DataW-1:0] item;
    logic                    last;
    logic                    empty;
    logic                    refused;
  } dump_word_t;

  // Shadow copy of the list, front first, and the dump words still to arrive.
  logic signed [DataW-1:0] shadow_list[$];
  dump_word_t              dump_words[$];
  int                      mismatches = 0;

  task automatic apply_command(input logic [OpW-1:0] op,
                               input logic signed [DataW-1:0] val,
                               input logic [PosW-1:0] pos);
    logic       turned_away;
    dump_word_t w;
    turned_away = 1'b0;
    case (op)
      OpFront, OpBack: begin
        if (shadow_list.size() >= CAPACITY) begin
          turned_away = 1'b1;
        end else if (op == OpFront) begin
          shadow_list.insert(0, val);
        end else begin
          shadow_list.insert(shadow_list.size(), val);
        end
      end
      OpDelete: begin
        if (pos < shadow_list.size()) begin
          shadow_list.delete(pos);
        end
      end
      default: begin
      end
    endcase
    if (shadow_list.size() == 0) begin
      w.item    = '0;
      w.last    = 1'b1;
      w.empty   = 1'b1;
      w.refused = turned_away;
      dump_words.insert(dump_words.size(), w);
    end else begin
      for (int i = 0; i < shadow_list.size(); i++) begin
        w.item    = shadow_list[i];
        w.last    = (i == shadow_list.size() - 1);
        w.empty   = 1'b0;
        w.refused = turned_away;
        dump_words.insert(dump_words.size(), w);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Results are checked before a command taken at the same edge adds its
      // own dump, although the queue order makes either order safe.
      if (out_strobe_o) begin
        if (dump_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got item %0h last %0b empty %0b refused %0b",
                   $time, item_o, last_o, empty_res_o, refused_o);
          mismatches++;
        end else begin
          dump_word_t want;
          want = dump_words.pop_front();
          compare_field("item", want.item, item_o);
          compare_field("last", want.last, last_o);
          compare_field("empty_res", want.empty, empty_res_o);
          compare_field("refused", want.refused, refused_o);
        end
      end
      if (start && !busy) begin
        apply_command(op_i, value_i, position_i);
      end
    end
    fail_count <= mismatches;
    pending    <= dump_words.size();
  end

endmodule

FILE: tb/sv/tb_bounded_list_insert_delete_dump_top.sv
// Testbench top for the bounded list: clock, reset, command stimulus and the verdict.
module tb_bounded_list_insert_delete_dump_top;
  import blid_pkg::*;

  localparam int Cap = 16;
  // The fourth op code has no name in the package; the block must treat it as
  // a no-op that still dumps the list.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [OpW-1:0]          op_i;
  logic signed [DataW-1:0] value_i;
  logic [PosW-1:0]         position_i;
  logic                    out_strobe_o;
  logic signed [DataW-1:0] item_o;
  logic                    last_o;
  logic                    empty_res_o;
  logic                    refused_o;
  int                      fail_count;
  int                      pending;

  // Stimulus-side estimate of the list length. It only steers which positions
  // get deleted; the checker keeps the real prediction.
  int                      depth;
  // Chance in percent that the sender sits out any given cycle.
  int                      idle_pct;

  bounded_list_insert_delete_dump_top #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_strobe_o(out_strobe_o),
    .item_o      (item_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .refused_o   (refused_o)
  );

  blid_list_checker #(
    .CAPACITY(Cap)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_strobe_o(out_strobe_o),
    .item_o      (item_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .refused_o   (refused_o),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hands one command word to the block. Before it the sender may sit idle
  // for a random number of cycles; start is then held high until an edge
  // finds busy low. On return start is still high, so a back-to-back word
  // simply overwrites the fields without dropping start in between.
  task automatic send_command(input logic [OpW-1:0] op,
                              input logic signed [DataW-1:0] val,
                              input logic [PosW-1:0] pos);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (op)
      OpFront, OpBack: if (depth < Cap) depth++;
      OpDelete:        if (pos < depth) depth--;
      default: begin
      end
    endcase
  endtask

  // Mostly full-range random words, with the two's complement extremes, zero
  // and minus one mixed in often.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic             grow;
    logic [OpW-1:0]   op;
    logic [PosW-1:0]  pos;
    int               roll;
    int               idle_choice[3];

    start      = 1'b0;
    op_i       = OpFront;
    value_i    = '0;
    position_i = '0;
    rst_ni     = 1'b0;
    depth      = 0;
    idle_pct   = 0;
    grow       = 1'b1;
    idle_choice[0] = 0;
    idle_choice[1] = 57;
    idle_choice[2] = 6;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. An empty list first sees a delete that is out of range
    // and the unused op code, both of which must still give an empty dump.
    send_command(OpDelete, 32'h1234_5678, 6'd0);
    send_command(OpUnused, 32'h0bad_f00d, 6'd63);
    // Extremes of the value field at both ends of the list.
    send_command(OpFront, 32'h7fff_ffff, 6'd63);
    send_command(OpBack, 32'h8000_0000, 6'd0);
    send_command(OpFront, 32'h0000_0000, 6'd21);
    send_command(OpBack, 32'hffff_ffff, 6'd42);
    // A delete past the end leaves the list alone; one in the middle shifts.
    send_command(OpDelete, 32'hffff_ffff, 6'd63);
    send_command(OpDelete, 32'h0000_0000, 6'd1);
    // Fill the list to capacity with alternating bit patterns.
    for (int i = 0; i < 13; i++) begin
      send_command((i % 2) ? OpBack : OpFront,
                   (i % 2) ? 32'haaaa_aaaa : 32'h5555_5555, i[PosW-1:0]);
    end
    // Both insert kinds must be refused on a full list, and the whole list
    // must still come out with the refused flag on every word.
    send_command(OpFront, 32'h1111_1111, 6'd0);
    send_command(OpBack, 32'h2222_2222, 6'd0);
    send_command(OpUnused, 32'h3333_3333, 6'd0);
    // Delete the back entry, then the front one.
    send_command(OpDelete, 32'h4444_4444, 6'd15);
    send_command(OpDelete, 32'h4444_4444, 6'd0);

    // Random part. The list drifts between growing and shrinking so that it
    // keeps reaching both the empty and the full state; the sender's idle
    // rate changes from phase to phase.
    for (int phase = 0; phase < 9; phase++) begin
      idle_pct = idle_choice[phase % 3];
      for (int k = 0; k < 32; k++) begin
        if (depth == 0) begin
          grow = 1'b1;
        end else if (depth == Cap && $urandom_range(0, 3) == 0) begin
          grow = 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
          grow = !grow;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          op = OpUnused;
        end else if (roll < (grow ? 84 : 24)) begin
          op = $urandom_range(0, 1) ? OpFront : OpBack;
        end else begin
          op = OpDelete;
        end
        // Most deletes hit a live entry; some go anywhere in the field range.
        if ($urandom_range(0, 6) == 0 || depth == 0) begin
          pos = PosW'($urandom_range(0, 63));
        end else begin
          pos = PosW'($urandom_range(0, depth - 1));
        end
        send_command(op, pick_value(), pos);
      end
    end

    // Drain: an edge lets the checker record the last command, then wait for
    // every predicted word and beyond it for any stray output.
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * Cap + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("bounded_list_insert_delete_dump_top regression: pass");
    end else begin
      $display("bounded_list_insert_delete_dump_top regression: fail");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is well under a tenth of this.
  initial begin
    #2000000;
    $display("bounded_list_insert_delete_dump_top regression: fail");
    $finish;
  end

endmodule
